@@ hw/rtl/aat_pkg.sv @@
// Shared types and constants for the axis-aligned box transform pipeline.
package aat_pkg;

   localparam int COORD_W      = 32;
   localparam int AXIS_W       = 2;
   localparam int FRAC_BITS_DF = 16;

   typedef struct packed {
      logic        [AXIS_W-1:0]  axis;
      logic signed [COORD_W-1:0] m_from_x;
      logic signed [COORD_W-1:0] m_from_y;
      logic signed [COORD_W-1:0] m_from_z;
      logic signed [COORD_W-1:0] translate;
      logic signed [COORD_W-1:0] local_min_x;
      logic signed [COORD_W-1:0] local_min_y;
      logic signed [COORD_W-1:0] local_min_z;
      logic signed [COORD_W-1:0] local_max_x;
      logic signed [COORD_W-1:0] local_max_y;
      logic signed [COORD_W-1:0] local_max_z;
   } req_type;

   typedef struct packed {
      logic        [AXIS_W-1:0]  axis_out;
      logic signed [COORD_W-1:0] world_min;
      logic signed [COORD_W-1:0] world_max;
      logic signed [COORD_W-1:0] center;
      logic        [COORD_W-2:0] half_extent;
   } rsp_type;

   typedef struct packed {
      logic prod;
      logic pick;
   } adv_type;

endpackage

@@ hw/rtl/aat_term.sv @@
// One matrix term: both corner products, then the smaller and larger of the pair.
module aat_term #(
   parameter int FRAC_BITS = aat_pkg::FRAC_BITS_DF,
   parameter int PROD_W    = 2 * aat_pkg::COORD_W - aat_pkg::FRAC_BITS_DF
) (
   input  logic                               clock,
   input  aat_pkg::adv_type                   adv,
   input  logic signed [aat_pkg::COORD_W-1:0] coef,
   input  logic signed [aat_pkg::COORD_W-1:0] corner_lo,
   input  logic signed [aat_pkg::COORD_W-1:0] corner_hi,
   output logic signed [PROD_W-1:0]           pick_lo,
   output logic signed [PROD_W-1:0]           pick_hi
);
   import aat_pkg::*;

   logic signed [2*COORD_W-1:0] p_full;
   logic signed [2*COORD_W-1:0] q_full;
   logic signed [2*COORD_W-1:0] p_shr;
   logic signed [2*COORD_W-1:0] q_shr;
   logic signed [PROD_W-1:0]    p_in;
   logic signed [PROD_W-1:0]    q_in;
   logic signed [PROD_W-1:0]    p_ff;
   logic signed [PROD_W-1:0]    q_ff;
   logic signed [PROD_W-1:0]    lo_ff;
   logic signed [PROD_W-1:0]    hi_ff;

   assign p_full = (2*COORD_W)'(coef) * (2*COORD_W)'(corner_lo);
   assign q_full = (2*COORD_W)'(coef) * (2*COORD_W)'(corner_hi);
   assign p_shr  = p_full >>> FRAC_BITS;
   assign q_shr  = q_full >>> FRAC_BITS;
   assign p_in   = p_shr[PROD_W-1:0];
   assign q_in   = q_shr[PROD_W-1:0];

   always_ff @(posedge clock) begin
      if (adv.prod) begin
         p_ff <= p_in;
         q_ff <= q_in;
      end
      if (adv.pick) begin
         if (p_ff < q_ff) begin
            lo_ff <= p_ff;
            hi_ff <= q_ff;
         end else begin
            lo_ff <= q_ff;
            hi_ff <= p_ff;
         end
      end
   end

   assign pick_lo = lo_ff;
   assign pick_hi = hi_ff;

endmodule

@@ hw/rtl/aabb_affine_transform.sv @@
// Top level of the axis-aligned box transform pipeline.
// Each transaction carries one matrix row, its translation and the local box, and yields the
// world minimum, maximum, center and half extent on that axis. The pipeline takes one
// transaction every cycle while the result side does not stall, and presents its result through
// six register stages: input register, the six 32x32 multipliers, min/max select, two partial
// sums, final sum with saturation, and the center/half-extent adders that feed the output
// register. A stall on the result side holds only the stages that are full; empty stages still
// fill, so the input keeps flowing until the pipeline is completely occupied.
module aabb_affine_transform #(
   parameter int FRAC_BITS = aat_pkg::FRAC_BITS_DF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aat_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aat_pkg::rsp_type rsp_payload
);
   import aat_pkg::*;

   localparam int PROD_W = 2 * COORD_W - FRAC_BITS;
   localparam int SUM_W  = PROD_W + 2;
   localparam logic signed [COORD_W-1:0] CoordMax = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] CoordMin = {1'b1, {(COORD_W-1){1'b0}}};

   logic en1, en2, en3, en4, en5, en6;
   adv_type adv;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, s5_valid_in, rsp_valid_in;

   req_type                   s1_req_ff;
   logic        [AXIS_W-1:0]  s2_axis_ff, s3_axis_ff, s4_axis_ff, s5_axis_ff;
   logic signed [COORD_W-1:0] s2_trans_ff, s3_trans_ff;

   logic signed [PROD_W-1:0]  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

   logic signed [SUM_W-1:0]   lo_a_ff, lo_b_ff, hi_a_ff, hi_b_ff;
   logic signed [SUM_W-1:0]   lo_a_in, lo_b_in, hi_a_in, hi_b_in;
   logic signed [SUM_W-1:0]   lo_sum, hi_sum;
   logic signed [COORD_W-1:0] wmin_in, wmax_in, wmin_ff, wmax_ff;
   logic signed [COORD_W:0]   mid_sum, span;
   rsp_type                   rsp_ff, rsp_in;

   assign en6 = !rsp_valid_ff || !rsp_stall;
   assign en5 = !s5_valid_ff || en6;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign adv.prod = en2;
   assign adv.pick = en3;

   assign req_stall = !en1;

   assign s1_valid_in  = en1 ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = en2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = en3 ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in  = en4 ? s3_valid_ff : s4_valid_ff;
   assign s5_valid_in  = en5 ? s4_valid_ff : s5_valid_ff;
   assign rsp_valid_in = en6 ? s5_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         s5_valid_ff  <= s5_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   aat_term #(.FRAC_BITS(FRAC_BITS), .PROD_W(PROD_W)) u_term_x (
      .clock     (clock),
      .adv       (adv),
      .coef      (s1_req_ff.m_from_x),
      .corner_lo (s1_req_ff.local_min_x),
      .corner_hi (s1_req_ff.local_max_x),
      .pick_lo   (lo_x),
      .pick_hi   (hi_x)
   );

   aat_term #(.FRAC_BITS(FRAC_BITS), .PROD_W(PROD_W)) u_term_y (
      .clock     (clock),
      .adv       (adv),
      .coef      (s1_req_ff.m_from_y),
      .corner_lo (s1_req_ff.local_min_y),
      .corner_hi (s1_req_ff.local_max_y),
      .pick_lo   (lo_y),
      .pick_hi   (hi_y)
   );

   aat_term #(.FRAC_BITS(FRAC_BITS), .PROD_W(PROD_W)) u_term_z (
      .clock     (clock),
      .adv       (adv),
      .coef      (s1_req_ff.m_from_z),
      .corner_lo (s1_req_ff.local_min_z),
      .corner_hi (s1_req_ff.local_max_z),
      .pick_lo   (lo_z),
      .pick_hi   (hi_z)
   );

   assign lo_a_in = SUM_W'(s3_trans_ff) + SUM_W'(lo_x);
   assign lo_b_in = SUM_W'(lo_y) + SUM_W'(lo_z);
   assign hi_a_in = SUM_W'(s3_trans_ff) + SUM_W'(hi_x);
   assign hi_b_in = SUM_W'(hi_y) + SUM_W'(hi_z);

   assign lo_sum = lo_a_ff + lo_b_ff;
   assign hi_sum = hi_a_ff + hi_b_ff;

   always_comb begin
      if (lo_sum > SUM_W'(CoordMax)) begin
         wmin_in = CoordMax;
      end else if (lo_sum < SUM_W'(CoordMin)) begin
         wmin_in = CoordMin;
      end else begin
         wmin_in = lo_sum[COORD_W-1:0];
      end
      if (hi_sum > SUM_W'(CoordMax)) begin
         wmax_in = CoordMax;
      end else if (hi_sum < SUM_W'(CoordMin)) begin
         wmax_in = CoordMin;
      end else begin
         wmax_in = hi_sum[COORD_W-1:0];
      end
   end

   assign mid_sum = (COORD_W+1)'(wmin_ff) + (COORD_W+1)'(wmax_ff);
   assign span    = (COORD_W+1)'(wmax_ff) - (COORD_W+1)'(wmin_ff);

   always_comb begin
      rsp_in.axis_out    = s5_axis_ff;
      rsp_in.world_min   = wmin_ff;
      rsp_in.world_max   = wmax_ff;
      rsp_in.center      = mid_sum[COORD_W:1];
      rsp_in.half_extent = span[COORD_W-1:1];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_req_ff <= req_payload;
      end
      if (en2) begin
         s2_axis_ff  <= s1_req_ff.axis;
         s2_trans_ff <= s1_req_ff.translate;
      end
      if (en3) begin
         s3_axis_ff  <= s2_axis_ff;
         s3_trans_ff <= s2_trans_ff;
      end
      if (en4) begin
         s4_axis_ff <= s3_axis_ff;
         lo_a_ff    <= lo_a_in;
         lo_b_ff    <= lo_b_in;
         hi_a_ff    <= hi_a_in;
         hi_b_ff    <= hi_b_in;
      end
      if (en5) begin
         s5_axis_ff <= s4_axis_ff;
         wmin_ff    <= wmin_in;
         wmax_ff    <= wmax_in;
      end
      if (en6) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
